// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ellipse rasterizer RTL.
// Each macro assumes i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MER_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mer: same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define MER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mer: next-cycle implication failed");

`endif

// ===== rtl/mer_pkg.sv =====
// Types and codes for the midpoint ellipse rasterizer.
// No dependencies; imported by midpoint_ellipse_raster.
package mer_pkg;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        SQ_WAIT,
        SQ_MUL,
        SQ_ROUND,
        SQ_CHECK,
        SQ_STEP_A,
        SQ_STEP_B,
        SQ_EMIT
    } t_seq;

    typedef enum logic [3:0] {
        MS_SQ_RX,
        MS_SQ_RY,
        MS_RX2_RY,
        MS_START_SUM,
        MS_TT,
        MS_RY2_TT,
        MS_UU,
        MS_RX2_UU,
        MS_RX2_RY2,
        MS_SETUP_SUM
    } t_mstep;

endpackage

// ===== rtl/midpoint_ellipse_raster.sv =====
// Midpoint ellipse rasterizer: one shared multiplier under a sequencer.
// Depends on mer_pkg and assert_macros.svh.
//
// A start beat loads the center and radii and returns the four mirrored points of
// (0, radius_y); each advance beat runs one midpoint iteration and returns the next
// four points, with done set on the last set. An advance while idle or done returns
// nothing. The block handles one beat at a time and holds o_in_ready low while it
// works. A start, or an advance after which region 1 ends, also runs the region-2
// decision set-up. The single multiplier serves every product of the start and
// set-up sequences in turn, one product a cycle. A finished point set waits in
// the output register, and the block takes the next beat while it waits; a point
// set that is finished while the register is still full holds the block until
// the register is drained.
`include "assert_macros.svh"

module midpoint_ellipse_raster
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic [RADIUS_BITS-1:0]       i_radius_x,
    input  logic [RADIUS_BITS-1:0]       i_radius_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS:0]   o_point_a_x,
    output logic signed [COORD_BITS:0]   o_point_a_y,
    output logic signed [COORD_BITS:0]   o_point_b_x,
    output logic signed [COORD_BITS:0]   o_point_b_y,
    output logic signed [COORD_BITS:0]   o_point_c_x,
    output logic signed [COORD_BITS:0]   o_point_c_y,
    output logic signed [COORD_BITS:0]   o_point_d_x,
    output logic signed [COORD_BITS:0]   o_point_d_y,
    output logic                         o_in_second_region,
    output logic                         o_done_res
);

    localparam int CW  = COORD_BITS;
    localparam int OW  = COORD_BITS + 1;
    localparam int RW  = RADIUS_BITS;
    localparam int XW  = RADIUS_BITS + 1;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int SW  = 3 * RADIUS_BITS + 2;
    localparam int MW  = 2 * RADIUS_BITS + 4;
    localparam int DW  = 2 * MW;

    t_seq   r_seq, n_seq;
    t_mstep r_mstep, n_mstep;
    t_phase r_phase, n_phase;

    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [RW-1:0]        r_rx, n_rx, r_ry, n_ry;
    logic [SQW-1:0]       r_rx2, n_rx2, r_ry2, n_ry2;
    logic [XW-1:0]        r_x, n_x, r_y, n_y;
    logic [SW-1:0]        r_sx, n_sx, r_sy, n_sy;
    logic signed [DW-1:0] r_dec, n_dec, r_acc, n_acc;
    logic [DW-1:0]        r_prod, n_prod;
    logic                 r_moved, n_moved;
    logic                 r_second, n_second;

    logic                 r_out_valid, n_out_valid;
    logic signed [OW-1:0] r_pax, n_pax, r_pay, n_pay, r_pbx, n_pbx, r_pby, n_pby;
    logic signed [OW-1:0] r_pcx, n_pcx, r_pcy, n_pcy, r_pdx, n_pdx, r_pdy, n_pdy;
    logic                 r_out_second, n_out_second;
    logic                 r_out_done, n_out_done;

    logic [MW-1:0]        m_a, m_b;
    logic [DW-1:0]        m_p;
    logic [MW-1:0]        t_val, u_val;
    logic                 in_take;
    logic                 dec_pos;
    logic signed [OW-1:0] ex_cx, ex_cy, ex_ox, ex_oy;

    assign m_p     = DW'(m_a) * DW'(m_b);
    assign t_val   = (MW'(r_x) << 1) | MW'(1);
    assign u_val   = (r_y == '0) ? MW'(1) : MW'(r_y - XW'(1));
    assign dec_pos = !r_dec[DW-1] && (r_dec != '0);
    assign in_take = i_in_valid && o_in_ready;

    assign ex_cx = OW'(r_cx);
    assign ex_cy = OW'(r_cy);
    assign ex_ox = OW'(r_x);
    assign ex_oy = OW'(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_WAIT;
            r_mstep     <= MS_SQ_RX;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_mstep     <= n_mstep;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_rx         <= n_rx;
        r_ry         <= n_ry;
        r_rx2        <= n_rx2;
        r_ry2        <= n_ry2;
        r_x          <= n_x;
        r_y          <= n_y;
        r_sx         <= n_sx;
        r_sy         <= n_sy;
        r_dec        <= n_dec;
        r_acc        <= n_acc;
        r_prod       <= n_prod;
        r_moved      <= n_moved;
        r_second     <= n_second;
        r_pax        <= n_pax;
        r_pay        <= n_pay;
        r_pbx        <= n_pbx;
        r_pby        <= n_pby;
        r_pcx        <= n_pcx;
        r_pcy        <= n_pcy;
        r_pdx        <= n_pdx;
        r_pdy        <= n_pdy;
        r_out_second <= n_out_second;
        r_out_done   <= n_out_done;
    end

    always_comb begin
        n_seq        = r_seq;
        n_mstep      = r_mstep;
        n_phase      = r_phase;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_rx         = r_rx;
        n_ry         = r_ry;
        n_rx2        = r_rx2;
        n_ry2        = r_ry2;
        n_x          = r_x;
        n_y          = r_y;
        n_sx         = r_sx;
        n_sy         = r_sy;
        n_dec        = r_dec;
        n_acc        = r_acc;
        n_prod       = r_prod;
        n_moved      = r_moved;
        n_second     = r_second;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_pax        = r_pax;
        n_pay        = r_pay;
        n_pbx        = r_pbx;
        n_pby        = r_pby;
        n_pcx        = r_pcx;
        n_pcy        = r_pcy;
        n_pdx        = r_pdx;
        n_pdy        = r_pdy;
        n_out_second = r_out_second;
        n_out_done   = r_out_done;
        m_a          = '0;
        m_b          = '0;
        o_in_ready   = (r_seq == SQ_WAIT);

        case (r_seq)
            SQ_WAIT: begin
                if (in_take) begin
                    if (i_operation == OP_START) begin
                        n_cx     = i_center_x;
                        n_cy     = i_center_y;
                        n_rx     = i_radius_x;
                        n_ry     = i_radius_y;
                        n_x      = '0;
                        n_y      = XW'(i_radius_y);
                        n_sx     = '0;
                        n_second = 1'b0;
                        n_phase  = PH_R1;
                        n_mstep  = MS_SQ_RX;
                        n_seq    = SQ_MUL;
                    end else if (r_phase == PH_R1 || r_phase == PH_R2) begin
                        n_seq = SQ_STEP_A;
                    end
                end
            end
            SQ_MUL: begin
                n_prod = m_p;
                case (r_mstep)
                    MS_SQ_RX: begin
                        m_a     = MW'(r_rx);
                        m_b     = MW'(r_rx);
                        n_mstep = MS_SQ_RY;
                    end
                    MS_SQ_RY: begin
                        n_rx2   = SQW'(r_prod);
                        m_a     = MW'(r_ry);
                        m_b     = MW'(r_ry);
                        n_mstep = MS_RX2_RY;
                    end
                    MS_RX2_RY: begin
                        n_ry2   = SQW'(r_prod);
                        m_a     = MW'(r_rx2);
                        m_b     = MW'(r_ry);
                        n_mstep = MS_START_SUM;
                    end
                    MS_START_SUM: begin
                        n_sy  = SW'(r_prod << 1);
                        n_acc = (DW'(r_ry2) << 2) - (r_prod << 2) + DW'(r_rx2);
                        n_seq = SQ_ROUND;
                    end
                    MS_TT: begin
                        m_a     = t_val;
                        m_b     = t_val;
                        n_mstep = MS_RY2_TT;
                    end
                    MS_RY2_TT: begin
                        m_a     = MW'(r_prod);
                        m_b     = MW'(r_ry2);
                        n_mstep = MS_UU;
                    end
                    MS_UU: begin
                        n_acc   = r_prod;
                        m_a     = u_val;
                        m_b     = u_val;
                        n_mstep = MS_RX2_UU;
                    end
                    MS_RX2_UU: begin
                        m_a     = MW'(r_rx2);
                        m_b     = MW'(r_prod);
                        n_mstep = MS_RX2_RY2;
                    end
                    MS_RX2_RY2: begin
                        n_acc   = r_acc + (r_prod << 2);
                        m_a     = MW'(r_rx2);
                        m_b     = MW'(r_ry2);
                        n_mstep = MS_SETUP_SUM;
                    end
                    MS_SETUP_SUM: begin
                        n_acc = r_acc - (r_prod << 2);
                        n_seq = SQ_ROUND;
                    end
                    default: begin
                        n_seq = SQ_WAIT;
                    end
                endcase
            end
            SQ_ROUND: begin
                if (r_acc[DW-1]) begin
                    n_dec = (r_acc + DW'(1)) >>> 2;
                end else begin
                    n_dec = (r_acc + DW'(2)) >>> 2;
                end
                n_seq = SQ_CHECK;
            end
            SQ_CHECK: begin
                if (r_phase == PH_R1 && r_sx >= r_sy) begin
                    n_phase = PH_R2;
                    n_mstep = MS_TT;
                    n_seq   = SQ_MUL;
                end else if (r_phase == PH_R2 && r_y == '0) begin
                    n_phase = PH_DONE;
                    n_seq   = SQ_EMIT;
                end else begin
                    n_seq = SQ_EMIT;
                end
            end
            SQ_STEP_A: begin
                n_second = (r_phase == PH_R2);
                if (r_phase == PH_R2) begin
                    n_moved = !dec_pos;
                    n_y     = r_y - XW'(1);
                    n_sy    = r_sy - (SW'(r_rx2) << 1);
                    if (!dec_pos) begin
                        n_x  = r_x + XW'(1);
                        n_sx = r_sx + (SW'(r_ry2) << 1);
                    end
                end else begin
                    n_moved = !r_dec[DW-1];
                    n_x     = r_x + XW'(1);
                    n_sx    = r_sx + (SW'(r_ry2) << 1);
                    if (!r_dec[DW-1]) begin
                        n_y  = r_y - XW'(1);
                        n_sy = r_sy - (SW'(r_rx2) << 1);
                    end
                end
                n_seq = SQ_STEP_B;
            end
            SQ_STEP_B: begin
                if (r_second) begin
                    n_dec = r_dec + DW'(r_rx2) - DW'(r_sy)
                            + (r_moved ? DW'(r_sx) : DW'(0));
                end else begin
                    n_dec = r_dec + DW'(r_ry2) + DW'(r_sx)
                            - (r_moved ? DW'(r_sy) : DW'(0));
                end
                n_seq = SQ_CHECK;
            end
            SQ_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_pax        = ex_cx + ex_ox;
                    n_pay        = ex_cy + ex_oy;
                    n_pbx        = ex_cx - ex_ox;
                    n_pby        = ex_cy + ex_oy;
                    n_pcx        = ex_cx + ex_ox;
                    n_pcy        = ex_cy - ex_oy;
                    n_pdx        = ex_cx - ex_ox;
                    n_pdy        = ex_cy - ex_oy;
                    n_out_second = r_second;
                    n_out_done   = (r_phase == PH_DONE);
                    n_seq        = SQ_WAIT;
                end
            end
            default: begin
                n_seq = SQ_WAIT;
            end
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_point_a_x        = r_pax;
    assign o_point_a_y        = r_pay;
    assign o_point_b_x        = r_pbx;
    assign o_point_b_y        = r_pby;
    assign o_point_c_x        = r_pcx;
    assign o_point_c_y        = r_pcy;
    assign o_point_d_x        = r_pdx;
    assign o_point_d_y        = r_pdy;
    assign o_in_second_region = r_out_second;
    assign o_done_res         = r_out_done;

    `MER_ASSERT_NEXT(a_start_loads,
        in_take && i_operation == OP_START,
        r_seq == SQ_MUL && r_phase == PH_R1 && r_x == '0)
    `MER_ASSERT_NEXT(a_idle_advance_drops,
        in_take && i_operation == OP_ADVANCE && (r_phase == PH_IDLE || r_phase == PH_DONE),
        r_seq == SQ_WAIT && !$rose(r_out_valid))
    `MER_ASSERT_IMPLY(a_emit_settled,
        r_seq == SQ_EMIT,
        r_phase != PH_IDLE && !(r_phase == PH_R1 && r_sx >= r_sy)
            && !(r_phase == PH_R2 && r_y == '0))
    `MER_ASSERT_IMPLY(a_y_bounded,
        r_phase != PH_IDLE && r_seq != SQ_MUL,
        r_y <= XW'(r_ry))

endmodule
